@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers for clocked checks with synchronous reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FCD_ASSERT_IMPL(lbl, clk, rst_n, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |-> (con)) \
        else $error("fcd assertion failed");

// next-cycle implication
`define FCD_ASSERT_NEXT(lbl, clk, rst_n, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |=> (con)) \
        else $error("fcd assertion failed");

`endif

@@ hw/rtl/fcd_pkg.sv @@
// ----------------------------------------------------------------------------
// fcd_pkg
// shared types and constants of the per-client flood detector
// ----------------------------------------------------------------------------
package fcd_pkg;

    localparam int DEF_ENTRIES = 32;
    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_PER_LEVEL    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_QUICK_BURST_SECONDS = 1'b1;
    localparam logic [CFG_DATA_W-1:0] WINDOW_RESET = 16'd60;
    localparam logic [CFG_DATA_W-1:0] QUICK_RESET  = 16'd7;

    // record arithmetic
    localparam logic [15:0] COUNT_WRAP_AT   = 16'd65535;
    localparam logic [15:0] COUNT_WRAP_TO   = 16'd6;
    localparam logic [15:0] COUNT_SECOND_UP = 16'd10;
    localparam logic [2:0]  PHASE_LAST      = 3'd4;
    localparam logic [2:0]  PHASE_AT_WRAP   = 3'd1;
    localparam logic [7:0]  LEVEL_MAX       = 8'd255;

    // what the front decided for one word
    localparam int KIND_W = 2;
    typedef enum logic [KIND_W-1:0] {
        K_HIT,
        K_NEW,
        K_FULL
    } t_kind;

    localparam int TIME_W = 32;

endpackage

@@ hw/rtl/fcd_front.sv @@
// ----------------------------------------------------------------------------
// fcd_front
// key table with parallel match, free-entry search and insert on miss
// ----------------------------------------------------------------------------
module fcd_front import fcd_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_accept,
    input  logic [31:0]                               i_client_key,
    input  logic [TIME_W-1:0]                         i_now_seconds,
    output logic                                      o_push,
    output logic [KIND_W+$clog2(ENTRIES)+TIME_W-1:0]  o_task
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic [ENTRIES-1:0] r_valid;
    logic [31:0]        r_key [ENTRIES];

    logic             w_hit;
    logic [IDX_W-1:0] w_hit_idx;
    logic             w_free;
    logic [IDX_W-1:0] w_free_idx;
    logic             w_insert;
    t_kind            w_kind;
    logic [IDX_W-1:0] w_idx;

    // scan from the top so the lowest match and lowest free entry win
    always_comb begin
        w_hit      = 1'b0;
        w_hit_idx  = '0;
        w_free     = 1'b0;
        w_free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_key[i] == i_client_key)) begin
                w_hit     = 1'b1;
                w_hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                w_free     = 1'b1;
                w_free_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        if (w_hit) begin
            w_kind = K_HIT;
            w_idx  = w_hit_idx;
        end else if (w_free) begin
            w_kind = K_NEW;
            w_idx  = w_free_idx;
        end else begin
            w_kind = K_FULL;
            w_idx  = '0;
        end
    end

    assign w_insert = i_accept && !w_hit && w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_insert) begin
            r_valid[w_free_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            r_key[w_free_idx] <= i_client_key;
        end
    end

    assign o_push = i_accept;
    assign o_task = {w_kind, w_idx, i_now_seconds};

endmodule

@@ hw/rtl/fcd_queue.sv @@
// ----------------------------------------------------------------------------
// fcd_queue
// small fifo between the classifying front and the record update
// ----------------------------------------------------------------------------
module fcd_queue import fcd_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    logic w_push;
    logic w_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ hw/rtl/fcd_back.sv @@
// ----------------------------------------------------------------------------
// fcd_back
// record memory and the read-modify-write that produces each result
// ----------------------------------------------------------------------------
module fcd_back import fcd_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic [CFG_DATA_W-1:0]                     i_window_per_level,
    input  logic [CFG_DATA_W-1:0]                     i_quick_burst_seconds,
    input  logic                                      i_q_empty,
    input  logic [KIND_W+$clog2(ENTRIES)+TIME_W-1:0]  i_q_data,
    output logic                                      o_pop,
    output logic                                      o_valid,
    output logic [7:0]                                o_flood_level,
    output logic                                      o_is_new_client,
    output logic                                      o_table_full
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int TASK_W = KIND_W + IDX_W + TIME_W;
    localparam int PROD_W = 8 + CFG_DATA_W;

    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [15:0]       count;
        logic [2:0]        phase;   // count mod 5
        logic [7:0]        level;
    } t_rec;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CALC,
        B_DONE
    } t_state;

    t_rec              r_mem [ENTRIES];
    t_rec              r_rd_rec;
    t_state            r_state;
    t_kind             r_kind;
    logic [IDX_W-1:0]  r_idx;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_elapsed;
    logic [PROD_W-1:0] r_prod;

    t_kind             w_head_kind;
    logic [IDX_W-1:0]  w_head_idx;
    logic [TIME_W-1:0] w_head_now;
    logic              w_clear;
    logic [TIME_W-1:0] w_el;
    t_rec              w_base;
    t_rec              w_upd;
    t_rec              w_wr_rec;
    logic              w_wr_en;

    function automatic logic [7:0] level_up(input logic [7:0] lvl);
        return (lvl == LEVEL_MAX) ? lvl : lvl + 8'd1;
    endfunction

    assign w_head_kind = t_kind'(i_q_data[TASK_W-1 -: KIND_W]);
    assign w_head_idx  = i_q_data[TIME_W +: IDX_W];
    assign w_head_now  = i_q_data[TIME_W-1:0];

    assign o_pop = (r_state == B_IDLE) && !i_q_empty;

    // quiet long enough: start over
    assign w_clear = (r_rd_rec.level != 8'd0)
                  && (r_elapsed > {{(TIME_W-PROD_W){1'b0}}, r_prod});

    always_comb begin
        if (w_clear) begin
            w_base = '{start: r_now, count: 16'd0, phase: 3'd0, level: 8'd0};
            w_el   = '0;
        end else begin
            w_base = r_rd_rec;
            w_el   = r_elapsed;
        end
        w_upd       = w_base;
        w_upd.count = w_base.count + 16'd1;
        w_upd.phase = (w_base.phase == PHASE_LAST) ? 3'd0 : w_base.phase + 3'd1;
        if (w_upd.phase == 3'd0) begin
            if (w_el < {{(TIME_W-CFG_DATA_W){1'b0}}, i_quick_burst_seconds}) begin
                w_upd.level = level_up(w_upd.level);
            end
            if (w_upd.count >= COUNT_SECOND_UP) begin
                w_upd.level = level_up(w_upd.level);
            end
        end
        if (w_upd.count == COUNT_WRAP_AT) begin
            w_upd.count = COUNT_WRAP_TO;
            w_upd.phase = PHASE_AT_WRAP;
        end
    end

    always_comb begin
        if (r_kind == K_HIT) begin
            w_wr_rec = w_upd;
        end else begin
            w_wr_rec = '{start: r_now, count: 16'd0, phase: 3'd0, level: 8'd0};
        end
    end

    assign w_wr_en = (r_state == B_DONE) && (r_kind != K_FULL);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_rec <= r_mem[w_head_idx];
        end
        if (w_wr_en) begin
            r_mem[r_idx] <= w_wr_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    o_valid <= 1'b0;
                    if (o_pop) begin
                        r_kind  <= w_head_kind;
                        r_idx   <= w_head_idx;
                        r_now   <= w_head_now;
                        r_state <= (w_head_kind == K_HIT) ? B_CALC : B_DONE;
                    end
                end
                B_CALC: begin
                    r_elapsed <= r_now - r_rd_rec.start;
                    r_prod    <= PROD_W'(r_rd_rec.level) * PROD_W'(i_window_per_level);
                    r_state   <= B_DONE;
                end
                B_DONE: begin
                    o_valid         <= 1'b1;
                    o_flood_level   <= (r_kind == K_HIT) ? w_upd.level : 8'd0;
                    o_is_new_client <= (r_kind == K_NEW);
                    o_table_full    <= (r_kind == K_FULL);
                    r_state         <= B_IDLE;
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/per_client_flood_detector.sv @@
// ----------------------------------------------------------------------------
// per_client_flood_detector
// tracks per-client message bursts and reports each client's flood level
// ----------------------------------------------------------------------------
//   channel   handshake          payload
//   input     start / busy       i_client_key, i_now_seconds
//   result    o_valid strobe     o_flood_level, o_is_new_client, o_table_full
//   config    i_cfg_we           i_cfg_idx, i_cfg_data
//
// the front matches the key against all entries in the cycle a word is taken;
// the back reads the record, then a known client passes B_CALC (multiply) and
// B_DONE (compare and write-back), a new or full word only B_DONE, taking no
// new word till idle. busy rises while the 2-word queue between them is full.
// reset is synchronous: valid bits clear at once, no clearing pass is needed.
// each result stands for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module per_client_flood_detector import fcd_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [31:0]           i_client_key,
    input  logic [TIME_W-1:0]     i_now_seconds,
    output logic                  o_valid,
    output logic [7:0]            o_flood_level,
    output logic                  o_is_new_client,
    output logic                  o_table_full,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int TASK_W = KIND_W + IDX_W + TIME_W;

    logic [CFG_DATA_W-1:0] r_window_per_level;
    logic [CFG_DATA_W-1:0] r_quick_burst_seconds;

    logic              w_accept;
    logic              w_push;
    logic [TASK_W-1:0] w_task;
    logic              w_pop;
    logic              w_q_empty;
    logic              w_q_full;
    logic [TASK_W-1:0] w_q_data;
    logic              w_no_record;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_per_level    <= WINDOW_RESET;
            r_quick_burst_seconds <= QUICK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WINDOW_PER_LEVEL:    r_window_per_level    <= i_cfg_data;
                REG_QUICK_BURST_SECONDS: r_quick_burst_seconds <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy     = w_q_full;
    assign w_accept = start && !busy;

    fcd_front #(
        .ENTRIES (ENTRIES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_client_key  (i_client_key),
        .i_now_seconds (i_now_seconds),
        .o_push        (w_push),
        .o_task        (w_task)
    );

    fcd_queue #(
        .WIDTH (TASK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_task),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_full  (w_q_full),
        .o_data  (w_q_data)
    );

    fcd_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_window_per_level    (r_window_per_level),
        .i_quick_burst_seconds (r_quick_burst_seconds),
        .i_q_empty             (w_q_empty),
        .i_q_data              (w_q_data),
        .o_pop                 (w_pop),
        .o_valid               (o_valid),
        .o_flood_level         (o_flood_level),
        .o_is_new_client       (o_is_new_client),
        .o_table_full          (o_table_full)
    );

    assign w_no_record = o_is_new_client || o_table_full;

    // the back never finishes two words in adjacent cycles
    `FCD_ASSERT_NEXT(a_strobe_spaced, i_clk, i_rst_n, o_valid, !o_valid)
    // new record and full table are exclusive
    `FCD_ASSERT_IMPL(a_new_full_excl, i_clk, i_rst_n, o_valid, !(o_is_new_client && o_table_full))
    // only a known client can carry a nonzero level
    `FCD_ASSERT_IMPL(a_level_on_hit, i_clk, i_rst_n, o_valid && w_no_record, o_flood_level == 8'd0)
    // an accepted word always lands in the queue
    `FCD_ASSERT_NEXT(a_accept_queued, i_clk, i_rst_n, w_accept, !w_q_empty)

endmodule
